/* hdl/sine_burst_sample_buffer_top_assert.svh */
// assertion macros for the sample buffer rtl
// needs clock and reset in the scope of each use
`ifndef SINE_BURST_SAMPLE_BUFFER_TOP_ASSERT_SVH
`define SINE_BURST_SAMPLE_BUFFER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define SBSB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define SBSB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/sbsb_pkg.sv */
// types and constants of the sine burst sample buffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sbsb_pkg;

   // request kinds as decoded by the front end
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_BURST  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   localparam logic [15:0] SAMPLE_LIMIT = 16'd32767;
   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

   // one queued request
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [16:0] sample_value;
      logic [15:0]        start_index;
      logic [16:0]        burst_length;
      logic [31:0]        phase_step;
      logic [15:0]        amplitude;
   } cmd_type;

endpackage
`default_nettype wire

/* hdl/sine_burst_sample_buffer_top.sv */
// top level of the sine burst sample buffer
// depends on sbsb_pkg, sbsb_front and sbsb_back
`timescale 1ns / 1ps
`default_nettype none
// A mono buffer of 16-bit samples with three requests: append a clamped
// sample, add a sine burst into a window (zero filling from the old length
// up to its start first), and read a sample back. Every request gives one
// response carrying the read value, a status and the new length. Append, an
// unused action and a rejected burst go from acceptance straight to the
// response state; a read passes the read state first. A burst stays in the
// fill state while it zero fills between the old length and start_index,
// since the single write port of the sample memory stores one sample per
// cycle, then passes the burst and drain states. A response held by the
// receiver stalls the back end. A two entry request queue lets new requests
// be accepted while a burst runs.
// The memory is not cleared at reset and needs no clearing pass.
module sine_burst_sample_buffer_top #(
   parameter int MEM_DEPTH        = 65536,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // action [1:0]
   input  wire logic [1:0]   req_tuser,
   // sample_value [16:0], start_index [32:17], burst_length [49:33],
   // phase_step [81:50], amplitude [97:82], zero fill above
   input  wire logic [103:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // read_value [15:0], status [17:16], stored_length [34:18], zero fill above
   output logic [39:0]       rsp_tdata
);
   import sbsb_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // request intake and queue
   sbsb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop)
   );

   // execution and response
   sbsb_back #(
      .MEM_DEPTH        (MEM_DEPTH),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

/* hdl/sbsb_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sbsb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* hdl/sbsb_front.sv */
// front end: accepts requests, decodes the action, two entry queue
// depends on sbsb_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbsb_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [1:0]       req_tuser,
   input  wire logic [103:0]     req_tdata,
   output sbsb_pkg::cmd_type     cmd,
   output logic                  cmd_valid,
   input  wire logic             cmd_pop
);
   import sbsb_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    dec;
   logic       push;
   logic       pop;

   // decode the action into a request kind
   always_comb begin
      case (req_tuser)
         KIND_APPEND: dec.kind = KIND_APPEND;
         KIND_BURST:  dec.kind = KIND_BURST;
         KIND_READ:   dec.kind = KIND_READ;
         default:     dec.kind = KIND_NONE;
      endcase
      dec.sample_value = req_tdata[16:0];
      dec.start_index  = req_tdata[32:17];
      dec.burst_length = req_tdata[49:33];
      dec.phase_step   = req_tdata[81:50];
      dec.amplitude    = req_tdata[97:82];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule
`default_nettype wire

/* hdl/sbsb_back.sv */
// back end: sample memory, zero fill, sine burst pipeline and result register
// depends on sbsb_pkg, sbsb_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sine_burst_sample_buffer_top_assert.svh"
module sbsb_back #(
   parameter int MEM_DEPTH        = 65536,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sbsb_pkg::cmd_type cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [39:0]            rsp_tdata
);
   import sbsb_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int LW = $clog2(MEM_DEPTH + 1);
   localparam int SW = ((LW > 17) ? LW : 17) + 1;
   localparam int TW = $clog2(SINE_TABLE_DEPTH);
   localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FILL  = 3'd1;
   localparam logic [2:0] ST_BURST = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   typedef logic signed [15:0] rom_type [SINE_TABLE_DEPTH];

   // one sine entry in q1.15 from a fixed point taylor series
   function automatic logic signed [15:0] sine_entry(input int unsigned k);
      logic [63:0] u;
      logic [63:0] r;
      logic [63:0] f;
      logic [63:0] x;
      logic [63:0] mag;
      logic [1:0]  quad;
      longint      sum;
      longint      s;
      logic signed [15:0] v;
      u    = ({32'd0, k} << 32) / 64'(SINE_TABLE_DEPTH);
      quad = u[31:30];
      r    = {34'd0, u[29:0]};
      f    = quad[0] ? (64'h4000_0000 - r) : r;
      x    = (f * HALF_PI_Q30) >> 30;
      mag  = x;
      sum  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
         mag = (mag * x) >> 30;
         mag = (mag * x) >> 30;
         mag = mag / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) sum = sum - longint'(mag);
         else              sum = sum + longint'(mag);
      end
      if (sum < 0) sum = 0;
      s = (sum + 16384) >>> 15;
      if (s > 32767) s = 32767;
      v = 16'(s);
      return quad[1] ? -v : v;
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         t[k] = sine_entry(k);
      end
      return t;
   endfunction

   function automatic logic [30:0] p2_amp_mul(input logic [15:0] a, input logic [14:0] b);
      return 31'(a) * 31'(b);
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // control state
   logic [2:0]    state_ff, state_in;
   logic [LW-1:0] vl_ff, vl_in;
   logic [31:0]   phase_ff, phase_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [16:0]   rem_ff, rem_in;
   logic [LW-1:0] start_ff, start_in;
   logic [LW-1:0] end_ff, end_in;
   logic [LW-1:0] old_len_ff, old_len_in;
   logic [31:0]   step_ff, step_in;
   logic [15:0]   amp_ff, amp_in;
   logic [15:0]   res_rv_ff, res_rv_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;

   // burst pipeline
   logic          p1_v_ff, p2_v_ff, p3_v_ff;
   logic [TW-1:0] p1_idx_ff;
   logic [LW-1:0] p1_pos_ff, p2_pos_ff, p3_pos_ff;
   logic          p1_zero_ff;
   logic [15:0]   p2_old_ff, p3_old_ff;
   logic signed [15:0] rom_q_ff;
   logic [16:0]   p3_mag_ff;
   logic          p3_neg_ff;
   logic          issue;
   logic          pipe_empty;
   logic          in_burst;

   // memory ports
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;

   logic [SW-1:0]     burst_end;
   logic signed [16:0] clamped;
   logic [31+DW:0]    idx_prod;
   logic [14:0]       e_abs;
   logic [30:0]       amp_prod;
   logic [15:0]       m16, addend;
   logic              out_free;

   sbsb_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign burst_end  = SW'(cmd.start_index) + SW'(cmd.burst_length);
   assign idx_prod   = (32 + DW)'(phase_ff) * (32 + DW)'(SINE_TABLE_DEPTH);
   assign e_abs      = rom_q_ff[15] ? 15'(-rom_q_ff) : rom_q_ff[14:0];
   assign amp_prod   = 31'(p2_amp_mul(amp_ff, e_abs));
   assign pipe_empty = !p1_v_ff && !p2_v_ff && !p3_v_ff;
   assign in_burst   = (state_ff == ST_BURST) || (state_ff == ST_DRAIN);

   // append clamp to plus or minus the sample limit
   always_comb begin
      if (cmd.sample_value > 17'sd32767)       clamped = 17'sd32767;
      else if (cmd.sample_value < -17'sd32767) clamped = -17'sd32767;
      else                                     clamped = cmd.sample_value;
   end

   // write back stage arithmetic, wrapping add
   always_comb begin
      m16    = (p3_mag_ff > 17'(SAMPLE_LIMIT)) ? SAMPLE_LIMIT : p3_mag_ff[15:0];
      addend = p3_neg_ff ? 16'(16'd0 - m16) : m16;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      vl_in      = vl_ff;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      rem_in     = rem_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      old_len_in = old_len_ff;
      step_in    = step_ff;
      amp_in     = amp_ff;
      res_rv_in  = res_rv_ff;
      res_st_in  = res_st_ff;
      cmd_pop    = 1'b0;
      issue      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = AW'(vl_ff);
      wr_data    = 16'd0;
      rd_en      = 1'b0;
      rd_addr    = AW'(pos_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               res_rv_in = 16'd0;
               res_st_in = STAT_OK;
               state_in  = ST_RESP;
               case (cmd.kind)
                  KIND_APPEND: begin
                     if (vl_ff >= LW'(MEM_DEPTH)) begin
                        res_st_in = STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = clamped[15:0];
                        vl_in   = vl_ff + 1'b1;
                     end
                  end
                  KIND_BURST: begin
                     if (cmd.burst_length == 17'd0 || burst_end > SW'(MEM_DEPTH)) begin
                        res_st_in = STAT_FULL;
                     end else begin
                        start_in   = LW'(cmd.start_index);
                        end_in     = LW'(burst_end);
                        old_len_in = vl_ff;
                        step_in    = cmd.phase_step;
                        amp_in     = cmd.amplitude;
                        phase_in   = 32'd0;
                        rem_in     = cmd.burst_length;
                        if (SW'(vl_ff) < SW'(cmd.start_index)) begin
                           pos_in   = vl_ff;
                           state_in = ST_FILL;
                        end else begin
                           pos_in   = LW'(cmd.start_index);
                           state_in = ST_BURST;
                        end
                     end
                  end
                  KIND_READ: begin
                     if (SW'(cmd.start_index) >= SW'(vl_ff)) begin
                        res_st_in = STAT_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(cmd.start_index);
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     res_st_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_FILL: begin
            // zero the gap between the old length and the window
            wr_en   = 1'b1;
            wr_addr = AW'(pos_ff);
            wr_data = 16'd0;
            pos_in  = pos_ff + 1'b1;
            if (pos_ff + 1'b1 == start_ff) begin
               state_in = ST_BURST;
            end
         end
         ST_BURST: begin
            // one window sample enters the pipeline each cycle
            issue    = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = AW'(pos_ff);
            phase_in = phase_ff + step_ff;
            pos_in   = pos_ff + 1'b1;
            rem_in   = rem_ff - 1'b1;
            if (rem_ff == 17'd1) begin
               vl_in    = (old_len_ff >= end_ff) ? old_len_ff : end_ff;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               phase_in  = 32'd0;
               pos_in    = '0;
               res_st_in = STAT_OK;
               state_in  = ST_RESP;
            end
         end
         ST_READ: begin
            res_rv_in = rd_data;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, 17'(vl_ff), res_st_ff, res_rv_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // write back stage owns the write port during a burst
      if (p3_v_ff) begin
         wr_en   = 1'b1;
         wr_addr = AW'(p3_pos_ff);
         wr_data = p3_old_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vl_ff        <= '0;
         phase_ff     <= 32'd0;
         pos_ff       <= '0;
         rem_ff       <= 17'd0;
         rsp_valid_ff <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         p3_v_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vl_ff        <= vl_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_v_ff      <= issue;
         p2_v_ff      <= p1_v_ff;
         p3_v_ff      <= p2_v_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      old_len_ff  <= old_len_in;
      step_ff     <= step_in;
      amp_ff      <= amp_in;
      res_rv_ff   <= res_rv_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      // stage 1: table index and memory read issue
      p1_idx_ff   <= TW'(idx_prod >> 32);
      p1_pos_ff   <= pos_ff;
      p1_zero_ff  <= (pos_ff >= old_len_ff);
      // stage 2: table read, old sample captured
      rom_q_ff    <= SINE_ROM[p1_idx_ff];
      p2_old_ff   <= p1_zero_ff ? 16'd0 : rd_data;
      p2_pos_ff   <= p1_pos_ff;
      // stage 3: amplitude product
      p3_mag_ff   <= amp_prod[30:14];
      p3_neg_ff   <= rom_q_ff[15];
      p3_old_ff   <= p2_old_ff;
      p3_pos_ff   <= p2_pos_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SBSB_ASSERT_IMPLIES(a_pop_only_idle, cmd_pop, state_ff == ST_IDLE, "request taken while busy")
   `SBSB_ASSERT_IMPLIES(a_fill_below_start, state_ff == ST_FILL, pos_ff < start_ff, "fill past start")
   `SBSB_ASSERT_IMPLIES(a_wb_in_burst, p3_v_ff, in_burst, "burst write outside burst")
   `SBSB_ASSERT_NEXT(a_drain_done, (state_ff == ST_DRAIN) && pipe_empty, state_ff == ST_RESP, "drain stuck")
endmodule
`default_nettype wire
